>>> hdl/label_bounding_box_tracker_unit_assert.svh
// Assertion macros for the label bounding box tracker.
`ifndef LABEL_BOUNDING_BOX_TRACKER_UNIT_ASSERT_SVH
`define LABEL_BOUNDING_BOX_TRACKER_UNIT_ASSERT_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define LBBT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define LBBT_ASSERT(lbl, prop, msg) \
    `LBBT_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

>>> hdl/lbbt_pkg.sv
// Package: constants, types and label classification for the bounding box tracker.
package lbbt_pkg;

    localparam int LABELS_DEF     = 64;
    localparam int COORD_BITS_DEF = 10;
    localparam int LABEL_BITS     = 8;
    localparam int MASK_BITS      = 64;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct packed {
        logic wr_en;
        logic present;
    } t_upd_status;

    // Two-digit tooth number: tens 1..4, units 1..8.
    function automatic logic is_tooth(input logic [LABEL_BITS-1:0] lab);
        return (lab >= 8'd11 && lab <= 8'd18) || (lab >= 8'd21 && lab <= 8'd28) ||
               (lab >= 8'd31 && lab <= 8'd38) || (lab >= 8'd41 && lab <= 8'd48);
    endfunction

endpackage

>>> hdl/lbbt_in_if.sv
// Input stream interface: labelled voxel or query transfer.
interface lbbt_in_if #(
    parameter int COORD_BITS = 10
);
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [COORD_BITS-1:0] pos_z;
    logic [7:0]            label;

    modport source (output valid, mode, pos_x, pos_y, pos_z, label, input ready);
    modport sink   (input valid, mode, pos_x, pos_y, pos_z, label, output ready);
endinterface

>>> hdl/lbbt_out_if.sv
// Output stream interface: query result transfer.
interface lbbt_out_if #(
    parameter int COORD_BITS = 10
);
    logic                  valid;
    logic                  ready;
    logic                  present;
    logic [COORD_BITS-1:0] min_x;
    logic [COORD_BITS-1:0] min_y;
    logic [COORD_BITS-1:0] min_z;
    logic [COORD_BITS-1:0] max_x;
    logic [COORD_BITS-1:0] max_y;
    logic [COORD_BITS-1:0] max_z;

    modport source (output valid, present, min_x, min_y, min_z, max_x, max_y, max_z,
                    input ready);
    modport sink   (input valid, present, min_x, min_y, min_z, max_x, max_y, max_z,
                    output ready);
endinterface

>>> hdl/label_bounding_box_tracker_unit.sv
// Top level of the per-label bounding box tracker.
// Takes one voxel or query transfer per cycle unless the input is stalled. The label's box is read from a
// one-port-read, one-port-write RAM at the accept edge and written back in the next
// cycle; a box just written is forwarded to a following transfer of the same label.
// Seen flags sit in flip-flops cleared by reset; the box RAM needs no clearing.
// Input stalls only while a query result waits in the output register and the
// next query reaches the update stage.
`include "label_bounding_box_tracker_unit_assert.svh"

module label_bounding_box_tracker_unit
    import lbbt_pkg::*;
#(
    parameter int LABELS     = LABELS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [MASK_BITS-1:0] i_cfg_wr_data,
    lbbt_in_if.sink              i_in,
    lbbt_out_if.source           o_out
);

    localparam int LBL_W = $clog2(LABELS);
    localparam int CB    = COORD_BITS;
    localparam int BOX_W = 6 * CB;

    logic [MASK_BITS-1:0]  r_mask;
    logic                  r_seen [LABELS];

    logic                  r_s1_vld;
    logic                  r_s1_mode;
    logic [LABEL_BITS-1:0] r_s1_label;
    logic [CB-1:0]         r_s1_pos_x;
    logic [CB-1:0]         r_s1_pos_y;
    logic [CB-1:0]         r_s1_pos_z;

    logic                  r_wr_vld;
    logic [LBL_W-1:0]      r_wr_addr;
    logic [BOX_W-1:0]      r_wr_data;

    logic                  r_out_vld;
    logic                  r_out_present;
    logic [BOX_W-1:0]      r_out_box;

    logic                  w_stall;
    logic                  w_in_xfer;
    logic [LBL_W-1:0]      w_s1_idx;
    logic [LBL_W-1:0]      w_rd_addr;
    logic [BOX_W-1:0]      w_rd_data;
    logic [BOX_W-1:0]      w_box_cur;
    logic [BOX_W-1:0]      w_upd_data;
    logic [BOX_W-1:0]      w_q_box;
    logic                  w_wr_en;
    logic                  w_out_load;
    t_upd_status           w_status;

    assign w_s1_idx   = r_s1_label[LBL_W-1:0];
    assign w_stall    = r_s1_vld && (r_s1_mode == MODE_QUERY) && r_out_vld && !o_out.ready;
    assign i_in.ready = !w_stall;
    assign w_in_xfer  = i_in.valid && !w_stall;
    assign w_rd_addr  = w_stall ? w_s1_idx : i_in.label[LBL_W-1:0];
    assign w_box_cur  = (r_wr_vld && r_wr_addr == w_s1_idx) ? r_wr_data : w_rd_data;
    assign w_wr_en    = r_s1_vld && w_status.wr_en;
    assign w_out_load = r_s1_vld && (r_s1_mode == MODE_QUERY) && !w_stall;

    lbbt_ram #(
        .WIDTH (BOX_W),
        .DEPTH (LABELS)
    ) u_box_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_s1_idx),
        .i_wr_data (w_upd_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    lbbt_box_update #(
        .LABELS     (LABELS),
        .COORD_BITS (COORD_BITS)
    ) u_box_update (
        .i_mode    (r_s1_mode),
        .i_label   (r_s1_label),
        .i_pos_x   (r_s1_pos_x),
        .i_pos_y   (r_s1_pos_y),
        .i_pos_z   (r_s1_pos_z),
        .i_mask    (r_mask),
        .i_seen    (r_seen[w_s1_idx]),
        .i_box     (w_box_cur),
        .o_wr_data (w_upd_data),
        .o_box     (w_q_box),
        .o_status  (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '0;
            r_s1_vld  <= 1'b0;
            r_wr_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < LABELS; i++) begin
                r_seen[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_mask <= i_cfg_wr_data;
            end
            if (!w_stall) begin
                r_s1_vld <= i_in.valid;
            end
            r_wr_vld <= w_wr_en;
            if (w_wr_en) begin
                r_seen[w_s1_idx] <= 1'b1;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_mode  <= i_in.mode;
            r_s1_label <= i_in.label;
            r_s1_pos_x <= i_in.pos_x;
            r_s1_pos_y <= i_in.pos_y;
            r_s1_pos_z <= i_in.pos_z;
        end
        if (w_wr_en) begin
            r_wr_addr <= w_s1_idx;
            r_wr_data <= w_upd_data;
        end
        if (w_out_load) begin
            r_out_present <= w_status.present;
            r_out_box     <= w_q_box;
        end
    end

    assign o_out.valid   = r_out_vld;
    assign o_out.present = r_out_present;
    assign o_out.min_x   = r_out_box[0*CB +: CB];
    assign o_out.min_y   = r_out_box[1*CB +: CB];
    assign o_out.min_z   = r_out_box[2*CB +: CB];
    assign o_out.max_x   = r_out_box[3*CB +: CB];
    assign o_out.max_y   = r_out_box[4*CB +: CB];
    assign o_out.max_z   = r_out_box[5*CB +: CB];

    `LBBT_ASSERT(a_wr_only_sample, w_wr_en |-> r_s1_vld && r_s1_mode == MODE_SAMPLE, "box write without sample")
    `LBBT_ASSERT(a_seen_after_wr, w_wr_en |=> r_seen[$past(w_s1_idx)], "seen flag not set after box write")
    `LBBT_ASSERT(a_stall_holds, w_stall |=> r_s1_vld && r_s1_mode == MODE_QUERY, "stalled query left update stage")
    `LBBT_ASSERT(a_box_order_x, r_out_vld && r_out_present |-> o_out.min_x <= o_out.max_x, "min_x above max_x")
    `LBBT_ASSERT(a_box_order_z, r_out_vld && r_out_present |-> o_out.min_z <= o_out.max_z, "min_z above max_z")

endmodule

>>> hdl/lbbt_ram.sv
// Generic simple dual-port RAM with registered read.
module lbbt_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/lbbt_box_update.sv
// Box update logic: tracking check, box merge and query result selection.
module lbbt_box_update
    import lbbt_pkg::*;
#(
    parameter int LABELS     = LABELS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    i_mode,
    input  logic [LABEL_BITS-1:0]   i_label,
    input  logic [COORD_BITS-1:0]   i_pos_x,
    input  logic [COORD_BITS-1:0]   i_pos_y,
    input  logic [COORD_BITS-1:0]   i_pos_z,
    input  logic [MASK_BITS-1:0]    i_mask,
    input  logic                    i_seen,
    input  logic [6*COORD_BITS-1:0] i_box,
    output logic [6*COORD_BITS-1:0] o_wr_data,
    output logic [6*COORD_BITS-1:0] o_box,
    output t_upd_status             o_status
);

    localparam int CB = COORD_BITS;

    logic                  w_in_range;
    logic                  w_tracked;
    logic                  w_seen;
    logic [CB-1:0]         w_pos [3];
    logic [CB-1:0]         w_min [3];
    logic [CB-1:0]         w_max [3];

    assign w_in_range = {1'b0, i_label} < (LABEL_BITS+1)'(LABELS);
    assign w_tracked  = w_in_range &&
                        (is_tooth(i_label) || (i_label[7:6] == 2'b00 && i_mask[i_label[5:0]]));
    assign w_seen     = w_in_range && i_seen;

    assign w_pos[0] = i_pos_x;
    assign w_pos[1] = i_pos_y;
    assign w_pos[2] = i_pos_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_min[k] = i_box[k*CB +: CB];
            w_max[k] = i_box[(k+3)*CB +: CB];
            if (!w_seen || w_pos[k] < w_min[k]) begin
                w_min[k] = w_pos[k];
            end
            if (!w_seen || w_pos[k] > w_max[k]) begin
                w_max[k] = w_pos[k];
            end
        end
        o_wr_data = {w_max[2], w_max[1], w_max[0], w_min[2], w_min[1], w_min[0]};
    end

    assign o_status.wr_en   = (i_mode == MODE_SAMPLE) && w_tracked;
    assign o_status.present = w_tracked && w_seen;
    assign o_box            = o_status.present ? i_box : '0;

endmodule
